### hdl/obhist_pkg.sv
package obhist_pkg;

	localparam int IMG_SIZE_DEF   = 512;
	localparam int MAX_ORBIT_DEF  = 8192;
	localparam int COUNT_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF  = 28;

	localparam int REG_W = 14;
	localparam int IDX_W = 4;
	localparam int IN_W  = 88;
	localparam int OUT_W = 120;

	localparam logic [1:0] ACT_SAMPLE = 2'd0;
	localparam logic [1:0] ACT_READ   = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	localparam logic [1:0] PS_EXCLUDED = 2'd0;
	localparam logic [1:0] PS_ACCEPTED = 2'd1;
	localparam logic [1:0] PS_RANGE    = 2'd2;
	localparam logic [1:0] PS_NONE     = 2'd3;

	localparam logic [IDX_W-1:0] CFG_MAX_DEPTH  = 4'd0;
	localparam logic [IDX_W-1:0] CFG_MIN_LENGTH = 4'd1;
	localparam logic [IDX_W-1:0] CFG_RED_LOW    = 4'd2;
	localparam logic [IDX_W-1:0] CFG_RED_HIGH   = 4'd3;
	localparam logic [IDX_W-1:0] CFG_GREEN_LOW  = 4'd4;
	localparam logic [IDX_W-1:0] CFG_GREEN_HIGH = 4'd5;
	localparam logic [IDX_W-1:0] CFG_BLUE_LOW   = 4'd6;
	localparam logic [IDX_W-1:0] CFG_BLUE_HIGH  = 4'd7;

	localparam logic [REG_W-1:0] RST_MAX_DEPTH  = 14'd8000;
	localparam logic [REG_W-1:0] RST_MIN_LENGTH = 14'd500;
	localparam logic [REG_W-1:0] RST_RED_LOW    = 14'd2000;
	localparam logic [REG_W-1:0] RST_RED_HIGH   = 14'd8000;
	localparam logic [REG_W-1:0] RST_GREEN_LOW  = 14'd1300;
	localparam logic [REG_W-1:0] RST_GREEN_HIGH = 14'd5000;
	localparam logic [REG_W-1:0] RST_BLUE_LOW   = 14'd0;
	localparam logic [REG_W-1:0] RST_BLUE_HIGH  = 14'd2000;

endpackage

### hdl/obhist_mul.sv
module obhist_mul import obhist_pkg::*; #(
	parameter int W = 34
) (
	input  logic                  clk,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic signed [2*W-1:0] p
);

	// one signed product per cycle, registered
	always_ff @(posedge clk) begin
		p <= (2*W)'(a) * (2*W)'(b);
	end

endmodule

### hdl/obhist_hist_bank.sv
module obhist_hist_bank import obhist_pkg::*; #(
	parameter int AW = 18,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic [AW-1:0] addr,
	input  logic          we,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

### hdl/buddhabrot_orbit_histogram_unit.sv
// Sequence: a sample runs the cardioid, then the bulb shape test, and ends if one rejects
// it (c outside the square of side 4 skips both); otherwise it iterates, then replays each
// remembered visit when any band takes the orbit; reads fetch one pixel, clears zero all.
// Throughput: one transaction at a time; the next input is taken only back in idle, once
// the result has gone to the output register.
// Reset: asynchronous, active low; registers take their defaults and a clearing pass
// zeroes the histograms before the first input is taken.
module buddhabrot_orbit_histogram_unit import obhist_pkg::*; #(
	parameter int IMG_SIZE   = IMG_SIZE_DEF,
	parameter int MAX_ORBIT  = MAX_ORBIT_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// c_real[31:0], c_imag[63:32], pixel_col[72:64], pixel_row[81:73]
	input  logic [IN_W-1:0]  s_tdata,
	// action[1:0]
	input  logic [1:0]       s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// orbit_length[13:0], channels_added[16:14], red_count[48:17],
	// green_count[80:49], blue_count[112:81]
	output logic [OUT_W-1:0] m_tdata,
	// point_status[1:0]
	output logic [1:0]       m_tuser,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0] cfg_data
);

	localparam int IMG_BITS = $clog2(IMG_SIZE);
	localparam int PIX_BITS = 2 * IMG_BITS;
	localparam int ORB_BITS = $clog2(MAX_ORBIT);
	localparam int FW       = $clog2(MAX_ORBIT + 1);
	localparam int LW       = (FW > REG_W) ? FW : REG_W;
	localparam int OW       = (FRAC_BITS + 5 > 34) ? FRAC_BITS + 5 : 34;
	localparam int PW       = 2 * OW;
	localparam int CW       = (IMG_BITS > 9) ? IMG_BITS : 9;
	localparam int SH       = FRAC_BITS - IMG_BITS + 2;

	localparam logic signed [OW-1:0] TWO_C     = OW'(1) << (FRAC_BITS + 1);
	localparam logic signed [OW-1:0] ONE_C     = OW'(1) << FRAC_BITS;
	localparam logic signed [OW-1:0] QUARTER_C = OW'(1) << (FRAC_BITS - 2);
	localparam logic signed [OW-1:0] HALF_M1_C = OW'(IMG_SIZE / 2 - 1);
	localparam logic signed [OW-1:0] IMG_C     = OW'(IMG_SIZE);
	localparam logic signed [PW-1:0] LHS_LIM_C  = PW'(1) << (2 * FRAC_BITS);
	localparam logic signed [PW-1:0] BULB_LIM_C = PW'(1) << (2 * FRAC_BITS - 4);
	localparam logic signed [PW-1:0] ESC_LIM_C  = PW'(1) << (2 * FRAC_BITS + 2);
	localparam logic [COUNT_BITS-1:0] CNT_MAX_C = {COUNT_BITS{1'b1}};
	localparam logic [PIX_BITS-1:0] PIX_LAST_C  = {PIX_BITS{1'b1}};

	typedef enum logic [21:0] {
		ST_IDLE = 22'(1) << 0,
		ST_CLR  = 22'(1) << 1,
		ST_EX0  = 22'(1) << 2,
		ST_EX1  = 22'(1) << 3,
		ST_EX2  = 22'(1) << 4,
		ST_EX3  = 22'(1) << 5,
		ST_EX4  = 22'(1) << 6,
		ST_EX5  = 22'(1) << 7,
		ST_IT0  = 22'(1) << 8,
		ST_IT1  = 22'(1) << 9,
		ST_IT2  = 22'(1) << 10,
		ST_IT3  = 22'(1) << 11,
		ST_IT4  = 22'(1) << 12,
		ST_IT5  = 22'(1) << 13,
		ST_IT6  = 22'(1) << 14,
		ST_FIN  = 22'(1) << 15,
		ST_RP0  = 22'(1) << 16,
		ST_RP1  = 22'(1) << 17,
		ST_RP2  = 22'(1) << 18,
		ST_RD0  = 22'(1) << 19,
		ST_RD1  = 22'(1) << 20,
		ST_DONE = 22'(1) << 21
	} state_t;

	state_t state_q;

	// configuration registers
	logic [REG_W-1:0] max_depth_q, min_length_q, red_low_q, red_high_q;
	logic [REG_W-1:0] green_low_q, green_high_q, blue_low_q, blue_high_q;

	// working registers
	logic signed [OW-1:0] cr_q, ci_q, x_q, b_q, q_q, zr_q, zi_q, nr_q, ni_q;
	logic signed [PW-1:0] y2_q, rr_q, t_q;
	logic [LW-1:0]        len_q;
	logic [FW-1:0]        fill_q, k_q;
	logic [PIX_BITS-1:0]  clr_cnt_q, rd_addr_q;
	logic                 rd_in_img_q, clr_done_q;
	logic [2:0]           ch_q;

	// result held until the output register is free
	logic [1:0]       res_status_q;
	logic [REG_W-1:0] res_len_q;
	logic [2:0]       res_ch_q;
	logic [31:0]      res_red_q, res_green_q, res_blue_q;

	logic              m_tvalid_q;
	logic [1:0]        m_status_q;
	logic [REG_W-1:0]  m_len_q;
	logic [2:0]        m_ch_q;
	logic [31:0]       m_red_q, m_green_q, m_blue_q;

	// shared multiplier
	logic signed [OW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod;

	// histogram ports
	logic [PIX_BITS-1:0]   h_addr;
	logic [2:0]            h_we;
	logic [COUNT_BITS-1:0] h_wr_r, h_wr_g, h_wr_b;
	logic [COUNT_BITS-1:0] h_rd_r, h_rd_g, h_rd_b;

	// orbit memory
	logic [PIX_BITS-1:0] orbit_mem [2**ORB_BITS];
	logic [PIX_BITS-1:0] orb_rd_q;
	logic                orb_we;

	// input fields
	logic [1:0]          in_action;
	logic signed [31:0]  in_cr, in_ci;
	logic [8:0]          in_col, in_row;
	logic [CW:0]         col_w, row_w;
	logic                in_img;

	logic [LW-1:0]        limit;
	logic signed [OW-1:0] px_c, py_c;
	logic                 pix_ok;
	logic [63:0]          r64, g64, b64;
	logic [2:0]           bands;
	logic                 take;

	function automatic logic unused_sum_gt();
		return ($signed(rr_q + prod) > ESC_LIM_C);
	endfunction

	assign in_cr     = s_tdata[31:0];
	assign in_ci     = s_tdata[63:32];
	assign in_col    = s_tdata[72:64];
	assign in_row    = s_tdata[81:73];
	assign in_action = s_tuser;
	assign col_w     = (CW + 1)'(in_col);
	assign row_w     = (CW + 1)'(in_row);
	assign in_img    = (col_w < (CW + 1)'(IMG_SIZE)) && (row_w < (CW + 1)'(IMG_SIZE));

	assign limit = (LW'(max_depth_q) > LW'(MAX_ORBIT)) ? LW'(MAX_ORBIT) : LW'(max_depth_q);

	// pixel of the new z
	assign px_c   = (nr_q >>> SH) + HALF_M1_C;
	assign py_c   = (ni_q >>> SH) + HALF_M1_C;
	assign pix_ok = (px_c >= 0) && (px_c < IMG_C) && (py_c >= 0) && (py_c < IMG_C)
	                && (fill_q < FW'(MAX_ORBIT));
	assign orb_we = (state_q == ST_IT6) && !(unused_sum_gt()) && pix_ok;

	// band membership of the finished length
	assign bands[0] = (len_q > LW'(red_low_q)) && (len_q < LW'(red_high_q));
	assign bands[1] = (len_q > LW'(green_low_q)) && (len_q < LW'(green_high_q));
	assign bands[2] = (len_q > LW'(blue_low_q)) && (len_q < LW'(blue_high_q));
	assign take     = (len_q > LW'(min_length_q)) && (len_q < limit);

	assign r64 = 64'(h_rd_r);
	assign g64 = 64'(h_rd_g);
	assign b64 = 64'(h_rd_b);

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_EX0: begin
				mul_a = ci_q;
				mul_b = ci_q;
			end
			ST_EX1: begin
				mul_a = x_q;
				mul_b = x_q;
			end
			ST_EX3: begin
				mul_a = q_q;
				mul_b = q_q + x_q;
			end
			ST_EX4: begin
				mul_a = b_q;
				mul_b = b_q;
			end
			ST_IT0: begin
				mul_a = zr_q;
				mul_b = zr_q;
			end
			ST_IT1: begin
				mul_a = zi_q;
				mul_b = zi_q;
			end
			ST_IT2: begin
				mul_a = zr_q;
				mul_b = zi_q;
			end
			ST_IT4: begin
				mul_a = nr_q;
				mul_b = nr_q;
			end
			ST_IT5: begin
				mul_a = ni_q;
				mul_b = ni_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// histogram address, write enables and saturating increment
	always_comb begin
		h_addr = orb_rd_q;
		h_we   = 3'b000;
		h_wr_r = (h_rd_r == CNT_MAX_C) ? h_rd_r : h_rd_r + 1'b1;
		h_wr_g = (h_rd_g == CNT_MAX_C) ? h_rd_g : h_rd_g + 1'b1;
		h_wr_b = (h_rd_b == CNT_MAX_C) ? h_rd_b : h_rd_b + 1'b1;
		case (state_q)
			ST_CLR: begin
				h_addr = clr_cnt_q;
				h_we   = 3'b111;
				h_wr_r = '0;
				h_wr_g = '0;
				h_wr_b = '0;
			end
			ST_RD0, ST_RD1: begin
				h_addr = rd_addr_q;
			end
			ST_RP2: begin
				h_we = ch_q;
			end
			default: begin
				h_we = 3'b000;
			end
		endcase
	end

	obhist_mul #(.W(OW)) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	obhist_hist_bank #(.AW(PIX_BITS), .DW(COUNT_BITS)) u_red (
		.clk   (clk),
		.addr  (h_addr),
		.we    (h_we[0]),
		.wdata (h_wr_r),
		.rdata (h_rd_r)
	);

	obhist_hist_bank #(.AW(PIX_BITS), .DW(COUNT_BITS)) u_green (
		.clk   (clk),
		.addr  (h_addr),
		.we    (h_we[1]),
		.wdata (h_wr_g),
		.rdata (h_rd_g)
	);

	obhist_hist_bank #(.AW(PIX_BITS), .DW(COUNT_BITS)) u_blue (
		.clk   (clk),
		.addr  (h_addr),
		.we    (h_we[2]),
		.wdata (h_wr_b),
		.rdata (h_rd_b)
	);

	// orbit memory: write during iteration, read during replay
	always_ff @(posedge clk) begin
		if (orb_we) begin
			orbit_mem[fill_q[ORB_BITS-1:0]] <= {py_c[IMG_BITS-1:0], px_c[IMG_BITS-1:0]};
		end
		orb_rd_q <= orbit_mem[k_q[ORB_BITS-1:0]];
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {7'd0, m_blue_q, m_green_q, m_red_q, m_ch_q, m_len_q};

	// configuration port: writes land at once, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_depth_q  <= RST_MAX_DEPTH;
			min_length_q <= RST_MIN_LENGTH;
			red_low_q    <= RST_RED_LOW;
			red_high_q   <= RST_RED_HIGH;
			green_low_q  <= RST_GREEN_LOW;
			green_high_q <= RST_GREEN_HIGH;
			blue_low_q   <= RST_BLUE_LOW;
			blue_high_q  <= RST_BLUE_HIGH;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_DEPTH:  max_depth_q  <= cfg_data;
				CFG_MIN_LENGTH: min_length_q <= cfg_data;
				CFG_RED_LOW:    red_low_q    <= cfg_data;
				CFG_RED_HIGH:   red_high_q   <= cfg_data;
				CFG_GREEN_LOW:  green_low_q  <= cfg_data;
				CFG_GREEN_HIGH: green_high_q <= cfg_data;
				CFG_BLUE_LOW:   blue_low_q   <= cfg_data;
				CFG_BLUE_HIGH:  blue_high_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// output register: drain on tready, load from the held result in DONE
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			m_status_q <= PS_NONE;
			m_len_q    <= '0;
			m_ch_q     <= '0;
			m_red_q    <= '0;
			m_green_q  <= '0;
			m_blue_q   <= '0;
		end else if ((state_q == ST_DONE) && (!m_tvalid_q || m_tready)) begin
			m_tvalid_q <= 1'b1;
			m_status_q <= res_status_q;
			m_len_q    <= res_len_q;
			m_ch_q     <= res_ch_q;
			m_red_q    <= res_red_q;
			m_green_q  <= res_green_q;
			m_blue_q   <= res_blue_q;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			clr_cnt_q    <= '0;
			clr_done_q   <= 1'b0;
			cr_q         <= '0;
			ci_q         <= '0;
			x_q          <= '0;
			b_q          <= '0;
			q_q          <= '0;
			zr_q         <= '0;
			zi_q         <= '0;
			nr_q         <= '0;
			ni_q         <= '0;
			y2_q         <= '0;
			rr_q         <= '0;
			t_q          <= '0;
			len_q        <= '0;
			fill_q       <= '0;
			k_q          <= '0;
			rd_addr_q    <= '0;
			rd_in_img_q  <= 1'b0;
			ch_q         <= '0;
			res_status_q <= PS_NONE;
			res_len_q    <= '0;
			res_ch_q     <= '0;
			res_red_q    <= '0;
			res_green_q  <= '0;
			res_blue_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						res_status_q <= PS_NONE;
						res_len_q    <= '0;
						res_ch_q     <= '0;
						res_red_q    <= '0;
						res_green_q  <= '0;
						res_blue_q   <= '0;
						cr_q         <= OW'(in_cr);
						ci_q         <= OW'(in_ci);
						rd_addr_q    <= {row_w[IMG_BITS-1:0], col_w[IMG_BITS-1:0]};
						rd_in_img_q  <= in_img;
						case (in_action)
							ACT_SAMPLE: state_q <= ST_EX0;
							ACT_READ:   state_q <= ST_RD0;
							ACT_CLEAR: begin
								clr_cnt_q  <= '0;
								clr_done_q <= 1'b1;
								state_q    <= ST_CLR;
							end
							default:    state_q <= ST_DONE;
						endcase
					end
				end
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == PIX_LAST_C) begin
						state_q <= clr_done_q ? ST_DONE : ST_IDLE;
					end
				end
				ST_EX0: begin
					// points outside the square of side 4 skip the shape tests
					x_q    <= cr_q - QUARTER_C;
					b_q    <= cr_q + ONE_C;
					zr_q   <= '0;
					zi_q   <= '0;
					len_q  <= LW'(1);
					fill_q <= '0;
					if (cr_q >= TWO_C || cr_q <= -TWO_C || ci_q >= TWO_C || ci_q <= -TWO_C) begin
						state_q <= ST_IT0;
					end else begin
						state_q <= ST_EX1;
					end
				end
				ST_EX1: begin
					y2_q    <= prod;
					state_q <= ST_EX2;
				end
				ST_EX2: begin
					q_q     <= OW'((prod + y2_q) >>> FRAC_BITS);
					state_q <= ST_EX3;
				end
				ST_EX3: begin
					state_q <= ST_EX4;
				end
				ST_EX4: begin
					// main cardioid
					if (prod < LHS_LIM_C && (prod <<< 2) < y2_q) begin
						res_status_q <= PS_EXCLUDED;
						state_q      <= ST_DONE;
					end else begin
						state_q <= ST_EX5;
					end
				end
				ST_EX5: begin
					// period-2 bulb
					if (prod + y2_q < BULB_LIM_C) begin
						res_status_q <= PS_EXCLUDED;
						state_q      <= ST_DONE;
					end else begin
						state_q <= ST_IT0;
					end
				end
				ST_IT0: begin
					state_q <= (len_q < limit) ? ST_IT1 : ST_FIN;
				end
				ST_IT1: begin
					rr_q    <= prod;
					state_q <= ST_IT2;
				end
				ST_IT2: begin
					t_q     <= rr_q - prod;
					state_q <= ST_IT3;
				end
				ST_IT3: begin
					nr_q    <= OW'((t_q >>> FRAC_BITS) + PW'(cr_q));
					ni_q    <= OW'(((prod <<< 1) >>> FRAC_BITS) + PW'(ci_q));
					state_q <= ST_IT4;
				end
				ST_IT4: begin
					if (nr_q > TWO_C || nr_q < -TWO_C || ni_q > TWO_C || ni_q < -TWO_C) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_IT5;
					end
				end
				ST_IT5: begin
					rr_q    <= prod;
					state_q <= ST_IT6;
				end
				ST_IT6: begin
					if (unused_sum_gt()) begin
						state_q <= ST_FIN;
					end else begin
						zr_q  <= nr_q;
						zi_q  <= ni_q;
						len_q <= len_q + 1'b1;
						if (pix_ok) begin
							fill_q <= fill_q + 1'b1;
						end
						state_q <= ST_IT0;
					end
				end
				ST_FIN: begin
					res_len_q <= len_q[REG_W-1:0];
					k_q       <= '0;
					if (take) begin
						res_status_q <= PS_ACCEPTED;
						res_ch_q     <= bands;
						ch_q         <= bands;
						state_q      <= (bands != 3'b000 && fill_q != '0) ? ST_RP0 : ST_DONE;
					end else begin
						res_status_q <= PS_RANGE;
						state_q      <= ST_DONE;
					end
				end
				ST_RP0: begin
					state_q <= ST_RP1;
				end
				ST_RP1: begin
					state_q <= ST_RP2;
				end
				ST_RP2: begin
					// write back and advance to the next remembered visit
					k_q     <= k_q + 1'b1;
					state_q <= (k_q == fill_q - 1'b1) ? ST_DONE : ST_RP0;
				end
				ST_RD0: begin
					state_q <= ST_RD1;
				end
				ST_RD1: begin
					if (rd_in_img_q) begin
						res_red_q   <= r64[31:0];
						res_green_q <= g64[31:0];
						res_blue_q  <= b64[31:0];
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						clr_done_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
